### hw/rtl/rjcs_pkg.sv
// Package for the JSON comment and trailing-comma stripper.
// Holds character codes, status codes, state enums and the queue entry type.
// No dependencies.
package rjcs_pkg;

	localparam int SPACE_DEPTH_DEF = 32;
	localparam int MAX_RESULTS     = 36;
	localparam int RES_CNT_W       = 6;
	localparam int Q_DEPTH         = 2;
	localparam int Q_AW            = $clog2(Q_DEPTH);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNCLOSED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [1:0] WS_SPACE = 2'd0;
	localparam logic [1:0] WS_TAB   = 2'd1;
	localparam logic [1:0] WS_CR    = 2'd2;
	localparam logic [1:0] WS_LF    = 2'd3;

	typedef enum logic [2:0] {
		M_NORMAL,
		M_QUOTED,
		M_QESC,
		M_LINE,
		M_BLOCK
	} strip_mode_t;

	typedef enum logic [1:0] {
		Q_NONE,
		Q_OPEN,
		Q_ESC
	} quote_state_t;

	typedef enum logic [1:0] {
		B_CHAR,
		B_COMMA,
		B_BUF,
		B_END
	} comma_state_t;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic       v0;
		logic       v1;
		logic       eoi;
		logic       unclosed;
	} strip_entry_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_of_run;
		logic       end_of_text;
		logic [1:0] status;
	} result_t;

endpackage

### hw/rtl/rjcs_strip.sv
// Front part: comment stripper. Classifies each input byte and turns it into
// up to two characters for the comma filter, packed as one queue entry.
// Depends on rjcs_pkg.
module rjcs_strip (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            in_byte,
	input  logic                  end_of_input,
	input  logic                  accept,
	output logic                  push,
	output rjcs_pkg::strip_entry_t entry
);
	import rjcs_pkg::*;

	strip_mode_t mode_q, mode_d;
	logic        slash_q, slash_d;
	logic        star_q, star_d;
	logic [7:0]  c;
	logic        crlf;

	assign c    = in_byte;
	assign crlf = (c == CH_CR) || (c == CH_LF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			slash_q <= slash_d;
			star_q  <= star_d;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		slash_d = slash_q;
		star_d  = star_q;
		entry   = '0;
		unique case (mode_q) inside
			M_QUOTED, M_QESC: begin
				entry.c0 = c;
				entry.v0 = 1'b1;
				if (mode_q == M_QESC)
					mode_d = M_QUOTED;
				else if (c == CH_BSLASH)
					mode_d = M_QESC;
				else if (c == CH_QUOTE)
					mode_d = M_NORMAL;
			end
			M_LINE: begin
				entry.v0 = 1'b1;
				if (crlf) begin
					entry.c0 = c;
					mode_d   = M_NORMAL;
				end else begin
					entry.c0 = CH_SPACE;
				end
			end
			M_BLOCK: begin
				if (star_q) begin
					star_d   = 1'b0;
					entry.c0 = CH_SPACE;
					entry.v0 = 1'b1;
					if (c == CH_SLASH) begin
						entry.c1 = CH_SPACE;
						entry.v1 = 1'b1;
						mode_d   = M_NORMAL;
					end else if (c == CH_STAR) begin
						star_d = 1'b1;
					end else begin
						entry.c1 = crlf ? c : CH_SPACE;
						entry.v1 = 1'b1;
					end
				end else if (c == CH_STAR) begin
					star_d = 1'b1;
				end else begin
					entry.c0 = crlf ? c : CH_SPACE;
					entry.v0 = 1'b1;
				end
			end
			default: begin
				mode_d = M_NORMAL;
				if (slash_q) begin
					slash_d = 1'b0;
					if (c == CH_SLASH || c == CH_STAR) begin
						entry.c0 = CH_SPACE;
						entry.v0 = 1'b1;
						entry.c1 = CH_SPACE;
						entry.v1 = 1'b1;
						mode_d   = (c == CH_SLASH) ? M_LINE : M_BLOCK;
						star_d   = 1'b0;
					end else begin
						entry.c0 = CH_SLASH;
						entry.v0 = 1'b1;
						entry.c1 = c;
						entry.v1 = 1'b1;
						if (c == CH_QUOTE)
							mode_d = M_QUOTED;
					end
				end else if (c == CH_QUOTE) begin
					entry.c0 = c;
					entry.v0 = 1'b1;
					mode_d   = M_QUOTED;
				end else if (c == CH_SLASH) begin
					slash_d = 1'b1;
				end else begin
					entry.c0 = c;
					entry.v0 = 1'b1;
				end
			end
		endcase

		if (end_of_input) begin
			entry.eoi      = 1'b1;
			entry.unclosed = (mode_d == M_BLOCK);
			if (slash_d) begin
				entry.c0 = CH_SLASH;
				entry.v0 = 1'b1;
			end
			if (mode_d == M_BLOCK && star_d) begin
				if (entry.v0) begin
					entry.c1 = CH_SPACE;
					entry.v1 = 1'b1;
				end else begin
					entry.c0 = CH_SPACE;
					entry.v0 = 1'b1;
				end
			end
			mode_d  = M_NORMAL;
			slash_d = 1'b0;
			star_d  = 1'b0;
		end
	end

	assign push = accept && (entry.v0 || entry.eoi);

endmodule

### hw/rtl/rjcs_queue.sv
// Short queue between the comment stripper and the comma filter.
// Holds stripped entries in flip-flops; depth from rjcs_pkg.
// Depends on rjcs_pkg.
module rjcs_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rjcs_pkg::strip_entry_t push_data,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output rjcs_pkg::strip_entry_t head
);
	import rjcs_pkg::*;

	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	strip_entry_t     slot_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full       = (cnt_q == CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

### hw/rtl/rjcs_comma.sv
// Back part: trailing-comma filter. Runs each queue entry through a small
// sequencer, buffers whitespace after a comma in a memory, and stages results.
// Depends on rjcs_pkg.
module rjcs_comma #(
	parameter int SPACE_DEPTH = rjcs_pkg::SPACE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  rjcs_pkg::strip_entry_t head,
	output logic                   q_pop,
	output logic                   dst_valid,
	input  logic                   dst_stall,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   last_of_run,
	output logic                   end_of_text,
	output logic [1:0]             status
);
	import rjcs_pkg::*;

	localparam int AW = $clog2(SPACE_DEPTH);
	localparam int CW = $clog2(SPACE_DEPTH + 1);

	function automatic logic is_ws(input logic [7:0] ch);
		return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
	endfunction

	function automatic logic [1:0] ws_code(input logic [7:0] ch);
		logic [1:0] code;
		case (ch)
			CH_TAB:  code = WS_TAB;
			CH_CR:   code = WS_CR;
			CH_LF:   code = WS_LF;
			default: code = WS_SPACE;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] ws_char(input logic [1:0] code);
		logic [7:0] ch;
		case (code)
			WS_TAB:  ch = CH_TAB;
			WS_CR:   ch = CH_CR;
			WS_LF:   ch = CH_LF;
			default: ch = CH_SPACE;
		endcase
		return ch;
	endfunction

	logic [1:0]     spc_mem [SPACE_DEPTH];
	logic [1:0]     rd_q;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;

	comma_state_t   st_q, st_d;
	quote_state_t   quote_q, quote_d;
	logic [1:0]     ci_q, ci_d;
	logic           pend_q, pend_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic           ovf_q, ovf_d;
	logic [RES_CNT_W-1:0] resn_q;

	result_t        stg_q, out_q, gen_res;
	logic           stg_valid_q, stg_final_q, out_valid_q;
	logic           gen_req, gen_final, gen_ok, gen_wr, drop;
	logic           mark, done, out_free, stg_move;
	logic [7:0]     cc;
	logic           have, keep, buf_last;
	logic [1:0]     end_status;

	assign cc   = (ci_q == 2'd0) ? head.c0 : head.c1;
	assign have = q_valid && ((ci_q == 2'd0 && head.v0) || (ci_q == 2'd1 && head.v1));
	assign keep = !(cc == CH_RBRACK || cc == CH_RBRACE);
	assign buf_last = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign end_status = head.unclosed ? ST_UNCLOSED : (ovf_q ? ST_OVERFLOW : ST_OK);

	assign out_free = !out_valid_q || !dst_stall;
	assign drop     = resn_q >= RES_CNT_W'(MAX_RESULTS);
	assign gen_ok   = drop || !stg_valid_q || out_free;
	assign gen_wr   = gen_req && gen_ok && !drop;
	assign stg_move = stg_valid_q && out_free && (stg_final_q || gen_wr);

	always_ff @(posedge clk) begin
		if (wr_en)
			spc_mem[cnt_q[AW-1:0]] <= ws_code(cc);
		rd_q <= spc_mem[rd_addr];
	end

	always_comb begin
		st_d      = st_q;
		quote_d   = quote_q;
		ci_d      = ci_q;
		pend_d    = pend_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		ovf_d     = ovf_q;
		gen_req   = 1'b0;
		gen_final = 1'b0;
		gen_res   = '0;
		mark      = 1'b0;
		done      = 1'b0;
		wr_en     = 1'b0;
		rd_addr   = '0;
		unique case (st_q)
			B_CHAR: begin
				if (q_valid) begin
					if (!have) begin
						st_d = B_END;
					end else if (quote_q != Q_NONE) begin
						gen_req            = 1'b1;
						gen_res.out_byte   = cc;
						gen_res.byte_valid = 1'b1;
						if (gen_ok) begin
							ci_d = ci_q + 2'd1;
							if (quote_q == Q_ESC)
								quote_d = Q_OPEN;
							else if (cc == CH_BSLASH)
								quote_d = Q_ESC;
							else if (cc == CH_QUOTE)
								quote_d = Q_NONE;
						end
					end else if (pend_q && is_ws(cc)) begin
						if (cnt_q < CW'(SPACE_DEPTH)) begin
							wr_en = 1'b1;
							cnt_d = cnt_q + CW'(1);
							ci_d  = ci_q + 2'd1;
						end else begin
							ovf_d  = 1'b1;
							pend_d = 1'b0;
							st_d   = B_COMMA;
						end
					end else if (pend_q) begin
						pend_d = 1'b0;
						if (keep)
							st_d = B_COMMA;
						else if (cnt_q != '0)
							st_d = B_BUF;
					end else if (cc == CH_COMMA) begin
						pend_d = 1'b1;
						cnt_d  = '0;
						ci_d   = ci_q + 2'd1;
					end else begin
						gen_req            = 1'b1;
						gen_res.out_byte   = cc;
						gen_res.byte_valid = 1'b1;
						if (gen_ok) begin
							ci_d = ci_q + 2'd1;
							if (cc == CH_QUOTE)
								quote_d = Q_OPEN;
						end
					end
				end
			end
			B_COMMA: begin
				gen_req            = 1'b1;
				gen_res.out_byte   = CH_COMMA;
				gen_res.byte_valid = 1'b1;
				if (gen_ok)
					st_d = (cnt_q != '0) ? B_BUF : B_CHAR;
			end
			B_BUF: begin
				gen_req            = 1'b1;
				gen_res.out_byte   = ws_char(rd_q);
				gen_res.byte_valid = 1'b1;
				rd_addr            = idx_q;
				if (gen_ok) begin
					if (buf_last) begin
						cnt_d   = '0;
						idx_d   = '0;
						rd_addr = '0;
						st_d    = B_CHAR;
					end else begin
						idx_d   = idx_q + AW'(1);
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			B_END: begin
				if (head.eoi && pend_q && quote_q == Q_NONE) begin
					pend_d = 1'b0;
					st_d   = B_COMMA;
				end else if (stg_valid_q && !stg_final_q) begin
					mark = 1'b1;
					done = 1'b1;
				end else if (head.eoi) begin
					gen_req             = 1'b1;
					gen_final           = 1'b1;
					gen_res.last_of_run = 1'b1;
					gen_res.end_of_text = 1'b1;
					gen_res.status      = end_status;
					done                = gen_ok;
				end else begin
					done = 1'b1;
				end
				if (done) begin
					ci_d = '0;
					st_d = B_CHAR;
					if (head.eoi) begin
						quote_d = Q_NONE;
						pend_d  = 1'b0;
						cnt_d   = '0;
						ovf_d   = 1'b0;
					end
				end
			end
			default: st_d = B_CHAR;
		endcase
	end

	assign q_pop = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_CHAR;
			quote_q     <= Q_NONE;
			ci_q        <= '0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			resn_q      <= '0;
			stg_valid_q <= 1'b0;
			stg_final_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			quote_q <= quote_d;
			ci_q    <= ci_d;
			pend_q  <= pend_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			ovf_q   <= ovf_d;
			if (done)
				resn_q <= '0;
			else if (gen_wr)
				resn_q <= resn_q + RES_CNT_W'(1);
			if (gen_wr) begin
				stg_valid_q <= 1'b1;
				stg_final_q <= gen_final;
			end else if (stg_move) begin
				stg_valid_q <= 1'b0;
				stg_final_q <= 1'b0;
			end else if (mark) begin
				stg_final_q <= 1'b1;
			end
			if (stg_move)
				out_valid_q <= 1'b1;
			else if (out_free)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_wr) begin
			stg_q <= gen_res;
		end else if (mark) begin
			stg_q.last_of_run <= 1'b1;
			stg_q.end_of_text <= head.eoi;
			stg_q.status      <= head.eoi ? end_status : ST_OK;
		end
		if (stg_move)
			out_q <= stg_q;
	end

	assign dst_valid   = out_valid_q;
	assign out_byte    = out_q.out_byte;
	assign byte_valid  = out_q.byte_valid;
	assign last_of_run = out_q.last_of_run;
	assign end_of_text = out_q.end_of_text;
	assign status      = out_q.status;

`ifndef ASSERT_OFF
	a_buf_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_BUF |-> cnt_q != '0)
		else $error("release sweep with empty whitespace buffer");
	a_final_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stg_final_q |-> stg_valid_q)
		else $error("final mark on empty staging register");
	a_final_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stg_valid_q && stg_final_q && !out_free |=> stg_valid_q && stg_final_q)
		else $error("final result lost while output stalled");
	a_pend_unquoted: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> quote_q == Q_NONE)
		else $error("comma pending inside a string");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(SPACE_DEPTH) && resn_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("buffer or result count out of range");
`endif

endmodule

### hw/rtl/relaxed_json_comment_comma_stripper_top.sv
// Top level of the JSON comment and trailing-comma stripper.
// Instantiates rjcs_strip, rjcs_queue and rjcs_comma; depends on rjcs_pkg.
//
//   channel  handshake              payload
//   src      src_valid, src_stall   in_byte, end_of_input
//   dst      dst_valid, dst_stall   out_byte, byte_valid, last_of_run, end_of_text, status
//
// The stripper takes one byte per cycle while the two-entry queue has room.
// The comma filter works through each queue entry character by character, then pops it from its end state.
// A released comma is sent from its own state and is followed by the buffered whitespace bytes;
// a dropped comma is left out, but its buffered whitespace bytes are still sent.
// dst_stall holds the output register; src_stall rises when the queue is full.
// arst_n clears all control state; the whitespace memory needs no clearing.
module relaxed_json_comment_comma_stripper_top #(
	parameter int SPACE_DEPTH = rjcs_pkg::SPACE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       end_of_text,
	output logic [1:0] status
);
	import rjcs_pkg::*;

	strip_entry_t push_data, head;
	logic         accept, push, full, pop, head_valid;

	assign src_stall = full;
	assign accept    = src_valid && !full;

	rjcs_strip u_strip (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.accept       (accept),
		.push         (push),
		.entry        (push_data)
	);

	rjcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rjcs_comma #(
		.SPACE_DEPTH (SPACE_DEPTH)
	) u_comma (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (head_valid),
		.head        (head),
		.q_pop       (pop),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text),
		.status      (status)
	);

endmodule
